// File: rtl/core/bhq_pkg.sv
// Shared widths, word types, codes and helpers of the binary min-heap queue.
package bhq_pkg;

	// Sizing: the heap holds HEAP_CAP entries spread over LEVELS tree levels.
	localparam int unsigned HEAP_CAP = 1024;
	localparam int unsigned KEY_W    = 32;
	localparam int unsigned TAG_W    = 16;
	localparam int unsigned CNT_W    = $clog2(HEAP_CAP + 1);
	localparam int unsigned NODE_W   = CNT_W;
	localparam int unsigned LEVELS   = $clog2(HEAP_CAP + 1);
	localparam int unsigned LVL_W    = $clog2(LEVELS);

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_REMOVE = 1'b1
	} req_type_t;

	typedef enum logic [1:0] {
		TOK_NONE  = 2'd0,
		TOK_INS   = 2'd1,
		TOK_FETCH = 2'd2,
		TOK_SIFT  = 2'd3
	} tok_kind_t;

	typedef enum logic [2:0] {
		S_IDLE  = 3'd0,
		S_INS   = 3'd1,
		S_FETCH = 3'd2,
		S_SIFT  = 3'd3,
		S_RESP  = 3'd4
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	// Token walking down the cell row. node is 1-based heap numbering.
	typedef struct packed {
		tok_kind_t         kind;
		logic              placed;
		logic [NODE_W-1:0] node;
		entry_t            ent;
		entry_t            head;
	} token_t;

	// Write handed up to the level above during sift-down.
	typedef struct packed {
		logic              valid;
		logic [NODE_W-1:0] node;
		entry_t            ent;
	} wb_t;

	// Per-operation control broadcast to every cell.
	typedef struct packed {
		logic [NODE_W-1:0] target;
		logic [LVL_W-1:0]  tgt_lvl;
		logic [CNT_W-1:0]  cnt;
	} ctl_t;

	typedef struct packed {
		req_type_t        req_type;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} req_word_t;

	typedef struct packed {
		logic [KEY_W-1:0] out_key;
		logic [TAG_W-1:0] out_tag;
		status_t          status;
		logic [CNT_W-1:0] entry_count;
	} rsp_word_t;

	// Tree level of a 1-based node number: position of its top set bit.
	function automatic logic [LVL_W-1:0] lvl_of(input logic [NODE_W-1:0] n);
		logic [LVL_W-1:0] l;
		l = '0;
		for (int i = 0; i < NODE_W; i++) begin
			if (n[i]) begin
				l = LVL_W'(i);
			end
		end
		return l;
	endfunction

endpackage

// File: rtl/core/binary_min_heap_queue_top.sv
// Top level of the binary min-heap priority queue: sequencer and row of level cells.
//
//  channel   | ports                     | handshake
//  ----------+---------------------------+----------------------------------------
//  request   | req (req_type, key, tag)  | word taken at clk edge with start & !busy
//  result    | rsp (out_key, out_tag,    | word valid for the one cycle done is high,
//            |  status, entry_count)     | taken at the edge ending that cycle
//
// Flow: one request at a time. An insert walks from the root to the new slot, with a
//   registered memory read, then a compare and write, at each level.
// A remove first sends a fetch word down the whole row (read and decided at the root
//   and at the last slot's level, passed straight on elsewhere), then sifts the moved
//   entry down, reading and deciding at each level walked.
// Full inserts and empty removes answer in the cycle after accept (busy for one cycle).
//   Reset clears the count and control registers but not the level memories; these
//   are never read past the count, so no clearing pass is needed.
// The result is a single-cycle strobe; the receiver cannot stall, so nothing waits on it.
//
// Structure: level L of the tree lives in cell L (2^L slots, the last level trimmed
// to what the capacity needs). Walk words move one cell down per step; during
// sift-down each cell hands the entry for its parent slot up to the cell above.
module binary_min_heap_queue_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  bhq_pkg::req_word_t req,
	output logic               done,
	output bhq_pkg::rsp_word_t rsp
);

	localparam int unsigned LEVELS = bhq_pkg::LEVELS;

	bhq_pkg::ctl_t   ctl;
	bhq_pkg::token_t chain [LEVELS+1];
	bhq_pkg::wb_t    wbs   [1:LEVELS];
	logic [LEVELS-1:0] cell_done;
	logic            cells_done;

	// nothing below the deepest level writes upward
	assign wbs[LEVELS] = '0;
	assign cells_done  = |cell_done;

	bhq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.done       (done),
		.rsp        (rsp),
		.ctl        (ctl),
		.tok_first  (chain[0]),
		.tok_last   (chain[LEVELS]),
		.cells_done (cells_done)
	);

	for (genvar g = 0; g < LEVELS; g++) begin : g_level
		if (g == 0) begin : g_root
			// the root has no parent to write into
			bhq_cell #(
				.LVL (g)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.tok_in  (chain[g]),
				.tok_out (chain[g+1]),
				.wb_in   (wbs[g+1]),
				.wb_out  (),
				.done    (cell_done[g])
			);
		end else begin : g_inner
			bhq_cell #(
				.LVL (g)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.tok_in  (chain[g]),
				.tok_out (chain[g+1]),
				.wb_in   (wbs[g+1]),
				.wb_out  (wbs[g]),
				.done    (cell_done[g])
			);
		end
	end

endmodule

// File: rtl/core/bhq_cell.sv
// One tree level of the heap: its entry memory and its step of each walk.
module bhq_cell #(
	parameter int unsigned LVL = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bhq_pkg::ctl_t   ctl,
	input  bhq_pkg::token_t tok_in,
	output bhq_pkg::token_t tok_out,
	input  bhq_pkg::wb_t    wb_in,
	output bhq_pkg::wb_t    wb_out,
	output logic            done
);

	localparam int unsigned NW    = bhq_pkg::NODE_W;
	localparam int unsigned LW    = bhq_pkg::LVL_W;
	localparam int unsigned SPAN  = 1 << LVL;
	localparam int unsigned ROOM  = bhq_pkg::HEAP_CAP + 1 - SPAN;
	localparam int unsigned DEPTH = (SPAN < ROOM) ? SPAN : ROOM;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [LW-1:0] MY_LVL   = LW'(LVL);
	localparam logic [LW-1:0] NEXT_LVL = LW'(LVL + 1);

	bhq_pkg::entry_t mem [DEPTH];
	bhq_pkg::entry_t rd0_q, rd1_q;
	bhq_pkg::token_t tok_s1, tok_q, tok_d;
	bhq_pkg::wb_t    wb_q, wb_d;
	bhq_pkg::entry_t own_wd, wd, pick_ent;
	logic            done_q, done_d;
	logic [AW-1:0]   ra0, ra1, wa, own_wa;
	logic            own_we, we;
	logic            take_now, pass_now, at_tgt;
	logic [NW:0]     lc, rc, pick, cnt_x;
	logic [NW+1:0]   pick_lc;
	logic            vl, vr, go_right, swap;

	// Slot of a 1-based node inside this level.
	function automatic logic [AW-1:0] addr_of(input logic [NW:0] node);
		logic [AW-1:0] a;
		a = '0;
		if (LVL != 0) begin
			a = node[AW-1:0];
		end
		return a;
	endfunction

	// Arrival: pick read addresses, decide whether the token stops here.
	always_comb begin
		take_now = 1'b0;
		pass_now = 1'b0;
		ra0      = addr_of({1'b0, tok_in.node});
		ra1      = addr_of({tok_in.node, 1'b1});
		case (tok_in.kind)
			bhq_pkg::TOK_INS: begin
				take_now = 1'b1;
			end
			bhq_pkg::TOK_FETCH: begin
				ra0 = addr_of({1'b0, ctl.target});
				if (LVL == 0 || MY_LVL == ctl.tgt_lvl) begin
					take_now = 1'b1;
				end else begin
					pass_now = 1'b1;
				end
			end
			bhq_pkg::TOK_SIFT: begin
				ra0 = addr_of({tok_in.node, 1'b0});
				if (LVL == 0) begin
					pass_now = 1'b1;
				end else begin
					take_now = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Decision on registered read data.
	always_comb begin
		tok_d    = '0;
		wb_d     = '0;
		done_d   = 1'b0;
		own_we   = 1'b0;
		own_wa   = addr_of({1'b0, tok_s1.node});
		own_wd   = tok_s1.ent;
		at_tgt   = (MY_LVL == ctl.tgt_lvl);
		cnt_x    = {1'b0, ctl.cnt};
		lc       = {tok_s1.node, 1'b0};
		rc       = {tok_s1.node, 1'b1};
		vl       = (lc <= cnt_x);
		vr       = (rc <= cnt_x);
		go_right = vr && !(rd0_q.key < rd1_q.key);
		pick     = go_right ? rc : lc;
		pick_ent = go_right ? rd1_q : rd0_q;
		swap     = vl && (pick_ent.key < tok_s1.ent.key);
		pick_lc  = {pick, 1'b0};
		if (pass_now) begin
			tok_d = tok_in;
		end
		case (tok_s1.kind)
			bhq_pkg::TOK_INS: begin
				if (at_tgt) begin
					own_we = 1'b1;
					done_d = 1'b1;
				end else begin
					tok_d.kind = bhq_pkg::TOK_INS;
					tok_d.node = NW'(ctl.target >> (ctl.tgt_lvl - NEXT_LVL));
					// once placed, every node below shifts down one level
					if (tok_s1.placed || (tok_s1.ent.key < rd0_q.key)) begin
						own_we       = 1'b1;
						tok_d.placed = 1'b1;
						tok_d.ent    = rd0_q;
					end else begin
						tok_d.ent = tok_s1.ent;
					end
				end
			end
			bhq_pkg::TOK_FETCH: begin
				tok_d = tok_s1;
				if (LVL == 0) begin
					tok_d.head = rd0_q;
				end
				if (at_tgt) begin
					tok_d.ent = rd0_q;
				end
			end
			bhq_pkg::TOK_SIFT: begin
				wb_d.valid = 1'b1;
				wb_d.node  = tok_s1.node;
				wb_d.ent   = tok_s1.ent;
				if (!swap) begin
					done_d = 1'b1;
				end else begin
					wb_d.ent = pick_ent;
					if (pick_lc <= {1'b0, cnt_x}) begin
						tok_d.kind = bhq_pkg::TOK_SIFT;
						tok_d.node = NW'(pick);
						tok_d.ent  = tok_s1.ent;
					end else begin
						// chosen child is a leaf: the moved entry lands here
						own_we = 1'b1;
						own_wa = addr_of(pick);
						done_d = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Writes from below and own writes never meet: one walk at a time.
	always_comb begin
		we = own_we | wb_in.valid;
		wa = wb_in.valid ? addr_of({1'b0, wb_in.node}) : own_wa;
		wd = wb_in.valid ? wb_in.ent : own_wd;
	end

	always_ff @(posedge clk) begin
		rd0_q <= mem[ra0];
		rd1_q <= mem[ra1];
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_q  <= '0;
			wb_q   <= '0;
			done_q <= 1'b0;
		end else begin
			if (take_now) begin
				tok_s1 <= tok_in;
			end else begin
				tok_s1 <= '0;
			end
			tok_q  <= tok_d;
			wb_q   <= wb_d;
			done_q <= done_d;
		end
	end

	assign tok_out = tok_q;
	assign wb_out  = wb_q;
	assign done    = done_q;

endmodule

// File: rtl/core/bhq_ctrl.sv
// Request sequencer of the heap queue: count, walk launch and result word.
module bhq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  bhq_pkg::req_word_t req,
	output logic               done,
	output bhq_pkg::rsp_word_t rsp,
	output bhq_pkg::ctl_t      ctl,
	output bhq_pkg::token_t    tok_first,
	input  bhq_pkg::token_t    tok_last,
	input  logic               cells_done
);

	localparam int unsigned CW = bhq_pkg::CNT_W;
	localparam int unsigned NW = bhq_pkg::NODE_W;
	localparam int unsigned LW = bhq_pkg::LVL_W;
	localparam int unsigned KW = bhq_pkg::KEY_W;
	localparam int unsigned TW = bhq_pkg::TAG_W;

	bhq_pkg::state_t  state_q, state_d;
	bhq_pkg::token_t  tok_q, tok_d;
	bhq_pkg::status_t status_q;
	logic [CW-1:0]    held_q, held_inc, held_dec;
	logic [NW-1:0]    tgt_q;
	logic [LW-1:0]    lvl_q;
	logic [KW-1:0]    key_q;
	logic [TW-1:0]    tag_q;
	logic             accept, full, empty, fetched;

	assign held_inc = held_q + 1'b1;
	assign held_dec = held_q - 1'b1;
	assign full     = (held_q == CW'(bhq_pkg::HEAP_CAP));
	assign empty    = (held_q == '0);
	assign fetched  = (tok_last.kind == bhq_pkg::TOK_FETCH);
	assign accept   = start && !busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			bhq_pkg::S_IDLE: begin
				if (start) begin
					if (req.req_type == bhq_pkg::REQ_INSERT) begin
						state_d = full ? bhq_pkg::S_RESP : bhq_pkg::S_INS;
					end else begin
						state_d = empty ? bhq_pkg::S_RESP : bhq_pkg::S_FETCH;
					end
				end
			end
			bhq_pkg::S_INS, bhq_pkg::S_SIFT: begin
				if (cells_done) begin
					state_d = bhq_pkg::S_RESP;
				end
			end
			bhq_pkg::S_FETCH: begin
				if (fetched) begin
					state_d = empty ? bhq_pkg::S_RESP : bhq_pkg::S_SIFT;
				end
			end
			bhq_pkg::S_RESP: begin
				state_d = bhq_pkg::S_IDLE;
			end
			default: begin
				state_d = bhq_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy      = (state_q != bhq_pkg::S_IDLE);
		done      = (state_q == bhq_pkg::S_RESP);
		rsp       = '{out_key: key_q, out_tag: tag_q, status: status_q, entry_count: held_q};
		ctl       = '{target: tgt_q, tgt_lvl: lvl_q, cnt: held_q};
		tok_first = tok_q;
	end

	// Walk word launched into the cell row on the next cycle.
	always_comb begin
		tok_d = '0;
		if (accept) begin
			if (req.req_type == bhq_pkg::REQ_INSERT) begin
				if (!full) begin
					// new slot is node count+1; walk root to it
					tok_d.kind = bhq_pkg::TOK_INS;
					tok_d.node = NW'(1);
					tok_d.ent  = '{key: req.key, tag: req.tag};
				end
			end else if (!empty) begin
				// fetch root and last slot in one pass
				tok_d.kind = bhq_pkg::TOK_FETCH;
			end
		end
		if (state_q == bhq_pkg::S_FETCH && fetched && !empty) begin
			tok_d.kind = bhq_pkg::TOK_SIFT;
			tok_d.node = NW'(1);
			tok_d.ent  = tok_last.ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bhq_pkg::S_IDLE;
			held_q   <= '0;
			tok_q    <= '0;
			tgt_q    <= '0;
			lvl_q    <= '0;
			status_q <= bhq_pkg::ST_OK;
			key_q    <= '0;
			tag_q    <= '0;
		end else begin
			state_q <= state_d;
			tok_q   <= tok_d;
			if (accept) begin
				key_q <= '0;
				tag_q <= '0;
				if (req.req_type == bhq_pkg::REQ_INSERT) begin
					if (full) begin
						status_q <= bhq_pkg::ST_FULL;
					end else begin
						status_q <= bhq_pkg::ST_OK;
						held_q   <= held_inc;
						tgt_q    <= NW'(held_inc);
						lvl_q    <= bhq_pkg::lvl_of(NW'(held_inc));
					end
				end else begin
					if (empty) begin
						status_q <= bhq_pkg::ST_EMPTY;
					end else begin
						status_q <= bhq_pkg::ST_OK;
						held_q   <= held_dec;
						tgt_q    <= NW'(held_q);
						lvl_q    <= bhq_pkg::lvl_of(NW'(held_q));
					end
				end
			end else if (state_q == bhq_pkg::S_FETCH && fetched) begin
				key_q <= tok_last.head.key;
				tag_q <= tok_last.head.tag;
			end
		end
	end

endmodule

// File: test/binary_min_heap_queue_top_test.sv
// Self-checking testbench of the binary min-heap queue: random bursts against a heap predictor.
`timescale 1ns / 100ps

module binary_min_heap_queue_top_test;

	localparam int unsigned IDLE_LIMIT = 5000;  // cycles with no word moving either way
	localparam int unsigned DRAIN_WAIT = 60;    // longer than the slowest remove
	localparam int unsigned MAX_REPORTS = 200;  // keep a broken run's log readable
	localparam int unsigned HEAP_CAP = bhq_pkg::HEAP_CAP;
	localparam int unsigned KEY_W = bhq_pkg::KEY_W;
	localparam int unsigned TAG_W = bhq_pkg::TAG_W;
	localparam int unsigned CNT_W = bhq_pkg::CNT_W;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	bhq_pkg::req_word_t req = '0;
	logic               done;
	bhq_pkg::rsp_word_t rsp;

	binary_min_heap_queue_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always #1 clk = ~clk;

	// Request words waiting to be sent, and result words owed by the block.
	bhq_pkg::req_word_t send_words[$];
	bhq_pkg::rsp_word_t owed_results[$];
	int unsigned gen_level = 0;   // heap size as the generator tracks it
	int unsigned mismatch_cnt = 0;
	int unsigned idle_cycles = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;

	// Predictor's own copy of the heap, 0-based array layout.
	bhq_pkg::entry_t heap_slots[HEAP_CAP];
	int unsigned     heap_len = 0;

	function automatic bhq_pkg::rsp_word_t heap_apply(input bhq_pkg::req_word_t w);
		bhq_pkg::rsp_word_t r;
		bhq_pkg::entry_t    tmp;
		int unsigned pos;
		int unsigned up;
		int unsigned lc;
		int unsigned rc;
		int unsigned pick;
		r = '0;
		r.status = bhq_pkg::ST_OK;
		if (w.req_type == bhq_pkg::REQ_INSERT) begin
			if (heap_len >= HEAP_CAP) begin
				r.status = bhq_pkg::ST_FULL;
			end else begin
				pos = heap_len;
				heap_slots[pos].key = w.key;
				heap_slots[pos].tag = w.tag;
				heap_len++;
				// climb while strictly smaller than the parent
				while (pos > 0) begin
					up = (pos - 1) / 2;
					if (heap_slots[pos].key < heap_slots[up].key) begin
						tmp = heap_slots[pos];
						heap_slots[pos] = heap_slots[up];
						heap_slots[up] = tmp;
						pos = up;
					end else begin
						break;
					end
				end
			end
		end else begin
			if (heap_len == 0) begin
				r.status = bhq_pkg::ST_EMPTY;
			end else begin
				r.out_key = heap_slots[0].key;
				r.out_tag = heap_slots[0].tag;
				heap_len--;
				heap_slots[0] = heap_slots[heap_len];
				pos = 0;
				// sink: left child only if strictly smaller than right, ties go right
				while (2 * pos + 1 < heap_len) begin
					lc = 2 * pos + 1;
					rc = 2 * pos + 2;
					pick = lc;
					if (rc < heap_len) begin
						pick = (heap_slots[lc].key < heap_slots[rc].key) ? lc : rc;
					end
					if (heap_slots[pick].key < heap_slots[pos].key) begin
						tmp = heap_slots[pick];
						heap_slots[pick] = heap_slots[pos];
						heap_slots[pos] = tmp;
						pos = pick;
					end else begin
						break;
					end
				end
			end
		end
		r.entry_count = CNT_W'(heap_len);
		return r;
	endfunction

	task automatic queue_word(input bhq_pkg::req_type_t kind, input logic [KEY_W-1:0] k,
			input logic [TAG_W-1:0] t);
		bhq_pkg::req_word_t w;
		w.req_type = kind;
		w.key = k;
		w.tag = t;
		send_words.push_back(w);
		if (kind == bhq_pkg::REQ_INSERT) begin
			if (gen_level < HEAP_CAP) gen_level++;
		end else if (gen_level > 0) begin
			gen_level--;
		end
	endtask

	// Keys lean toward a narrow range so that ties are common.
	function automatic logic [KEY_W-1:0] rand_key();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return KEY_W'($urandom_range(0, 15));
			4:          return {28'hFFF_FFFF, 4'($urandom_range(0, 15))};
			default:    return KEY_W'($urandom());
		endcase
	endfunction

	function automatic logic [TAG_W-1:0] rand_tag();
		return TAG_W'($urandom());
	endfunction

	task automatic queue_insert();
		queue_word(bhq_pkg::REQ_INSERT, rand_key(), rand_tag());
	endtask

	task automatic queue_remove();
		queue_word(bhq_pkg::REQ_REMOVE, rand_key(), rand_tag());
	endtask

	// Driver: holds start until the word is taken, then bursts and gaps at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				owed_results.push_back(heap_apply(req));
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (send_words.size() > 0) begin
					req <= send_words.pop_front();
					start <= 1'b1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(0, 39);
						case ($urandom_range(0, 9))
							0, 1, 2: gap_left = 0;
							3:       gap_left = $urandom_range(20, 60);
							default: gap_left = $urandom_range(1, 12);
						endcase
					end else begin
						burst_left--;
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobed result word is checked against the oldest owed one.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (owed_results.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_REPORTS)
					$error("result word with nothing owed: key %h tag %h status %0d count %0d",
						rsp.out_key, rsp.out_tag, rsp.status, rsp.entry_count);
			end else begin
				bhq_pkg::rsp_word_t want;
				want = owed_results.pop_front();
				if (rsp.out_key !== want.out_key) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$error("out_key: expected %h, got %h", want.out_key, rsp.out_key);
				end
				if (rsp.out_tag !== want.out_tag) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$error("out_tag: expected %h, got %h", want.out_tag, rsp.out_tag);
				end
				if (rsp.status !== want.status) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$error("status: expected %0d, got %0d", want.status, rsp.status);
				end
				if (rsp.entry_count !== want.entry_count) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$error("entry_count: expected %0d, got %0d",
							want.entry_count, rsp.entry_count);
				end
			end
		end
	end

	// Watchdog: ends a run that stops moving words.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned ins_pct;

		// Directed: empty remove, key and tag extremes, unsigned top bit, equal keys.
		queue_word(bhq_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
		queue_word(bhq_pkg::REQ_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
		queue_word(bhq_pkg::REQ_INSERT, 32'h0000_0000, 16'h0000);
		queue_word(bhq_pkg::REQ_INSERT, 32'h8000_0000, 16'h8000);
		queue_word(bhq_pkg::REQ_INSERT, 32'h7FFF_FFFF, 16'h7FFF);
		queue_word(bhq_pkg::REQ_INSERT, 32'd5, 16'd1);
		queue_word(bhq_pkg::REQ_INSERT, 32'd5, 16'd2);
		queue_word(bhq_pkg::REQ_INSERT, 32'd5, 16'd3);
		queue_word(bhq_pkg::REQ_INSERT, 32'd5, 16'd4);
		queue_word(bhq_pkg::REQ_INSERT, 32'd5, 16'd5);
		queue_word(bhq_pkg::REQ_INSERT, 32'd0, 16'hA5A5);
		repeat (11) queue_word(bhq_pkg::REQ_REMOVE, 32'd0, 16'd0);

		// Random: segments that push the level up or down.
		for (int seg = 0; seg < 10; seg++) begin
			case ($urandom_range(0, 3))
				0:       ins_pct = 20;
				1:       ins_pct = 50;
				2:       ins_pct = 80;
				default: ins_pct = 95;
			endcase
			for (int i = 0; i < 50; i++) begin
				if ($urandom_range(1, 100) <= ins_pct) queue_insert();
				else queue_remove();
			end
		end

		// Drain past empty.
		while (gen_level > 0) queue_remove();
		repeat (2) queue_remove();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (send_words.size() != 0 || start || owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatch_cnt == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/core/bhq_pkg.sv
rtl/core/bhq_cell.sv
rtl/core/bhq_ctrl.sv
rtl/core/binary_min_heap_queue_top.sv
test/binary_min_heap_queue_top_test.sv
